// ===== design/sitda_pkg.sv =====
package sitda_pkg;

    // Number of decimal digits needed for a 32-bit magnitude.
    localparam int NUM_DIGITS   = 10;
    localparam int BIN_W        = 32;
    localparam int BCD_W        = 4 * NUM_DIGITS;
    localparam int CNT_W        = 4;

    // Conversion stages; each one shifts a fixed slice of the binary word.
    localparam int NUM_STG      = 4;
    localparam int BITS_PER_STG = BIN_W / NUM_STG;

    // Character codes.
    localparam logic [5:0] CH_ZERO  = 6'd48;
    localparam logic [5:0] CH_MINUS = 6'd45;

    // Word traveling through the conversion pipeline.
    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] bcd;
        logic [BIN_W-1:0] bin;
    } t_conv;

endpackage

// ===== design/sitda_in_if.sv =====
interface sitda_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ===== design/sitda_out_if.sv =====
interface sitda_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== design/signed_int_to_decimal_ascii.sv =====
// An input transfer goes through the input register, the conversion stages and the
// serializer to the output. The serializer sends digits plus a minus sign (1 to 11),
// one character per transfer, and takes the next item with the current item's last character.
// The five conversion registers ahead of it keep taking items while it drains.
// Reset (synchronous, active low) clears all valid bits and the serializer state.
module signed_int_to_decimal_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sitda_in_if.sink    i_in,
    sitda_out_if.source o_out
);
    import sitda_pkg::*;

    logic [NUM_STG:0] v;
    logic [NUM_STG:0] rdy;
    t_conv            d [NUM_STG+1];

    logic             r0_valid;
    t_conv            r0_data;
    logic [BIN_W-1:0] n_mag;

    // Magnitude in unsigned arithmetic, so the most negative value is exact.
    assign n_mag = i_in.value[BIN_W-1] ? (BIN_W'(0) - i_in.value) : i_in.value;

    assign i_in.ready = !r0_valid || rdy[0];
    assign v[0]       = r0_valid;
    assign d[0]       = r0_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (i_in.ready) begin
            r0_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r0_data.neg <= i_in.value[BIN_W-1];
            r0_data.bcd <= '0;
            r0_data.bin <= n_mag;
        end
    end

    // Binary to BCD conversion, one slice of the word per stage.
    for (genvar k = 0; k < NUM_STG; k++) begin : g_stg
        sitda_dabble u_dab (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[k]),
            .i_data  (d[k]),
            .o_ready (rdy[k]),
            .o_valid (v[k+1]),
            .o_data  (d[k+1]),
            .i_ready (rdy[k+1])
        );
    end

    // Character serializer.
    sitda_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v[NUM_STG]),
        .i_data  (d[NUM_STG]),
        .o_ready (rdy[NUM_STG]),
        .o_out   (o_out)
    );

    // Only a minus sign or a decimal digit ever leaves.
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.character == CH_MINUS) ||
                        ((o_out.character >= CH_ZERO) && (o_out.character <= 6'd57)))
        else $error("character out of range");

    // A minus sign is never the final character.
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.character == CH_MINUS)) |-> !o_out.last)
        else $error("minus sign flagged last");

    // Once a number has started, its text continues until the last flag.
    a_text_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last) |=> o_out.valid)
        else $error("text ended without last flag");

    // A stalled first stage keeps its item.
    a_stage0_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r0_valid && !rdy[0]) |=> (r0_valid && $stable(r0_data)))
        else $error("first stage lost an item under stall");

endmodule

// ===== design/sitda_dabble.sv =====
module sitda_dabble (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  sitda_pkg::t_conv i_data,
    output logic            o_ready,
    output logic            o_valid,
    output sitda_pkg::t_conv o_data,
    input  logic            i_ready
);
    import sitda_pkg::*;

    logic  r_valid;
    t_conv r_data;
    t_conv n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Shift-and-add-3 over this stage's slice of the binary word.
    always_comb begin
        logic [BCD_W+BIN_W-1:0] acc;
        acc = {i_data.bcd, i_data.bin};
        for (int s = 0; s < BITS_PER_STG; s++) begin
            for (int j = 0; j < NUM_DIGITS; j++) begin
                if (acc[BIN_W + 4*j +: 4] >= 4'd5) begin
                    acc[BIN_W + 4*j +: 4] = acc[BIN_W + 4*j +: 4] + 4'd3;
                end
            end
            acc = acc << 1;
        end
        n_data.neg = i_data.neg;
        n_data.bcd = acc[BIN_W +: BCD_W];
        n_data.bin = acc[BIN_W-1:0];
    end

    // Valid bit of the stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== design/sitda_ser.sv =====
module sitda_ser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  sitda_pkg::t_conv i_data,
    output logic             o_ready,
    sitda_out_if.source      o_out
);
    import sitda_pkg::*;

    logic             r_busy;
    logic             r_minus;
    logic [BCD_W-1:0] r_digits;
    logic [CNT_W-1:0] r_cnt;

    logic [CNT_W-1:0] n_nd;
    logic [5:0]       n_sh;
    logic             last_w;
    logic             xfer;
    logic             load;

    // Count significant digits; zero still gives one digit.
    always_comb begin
        n_nd = CNT_W'(1);
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (i_data.bcd[4*k +: 4] != 4'd0) begin
                n_nd = CNT_W'(k + 1);
            end
        end
        n_sh = {2'b00, CNT_W'(NUM_DIGITS) - n_nd} << 2;
    end

    assign last_w  = !r_minus && (r_cnt == CNT_W'(1));
    assign xfer    = r_busy && o_out.ready;
    assign o_ready = !r_busy || (xfer && last_w);
    assign load    = o_ready && i_valid;

    // Output comes straight from the character registers.
    assign o_out.valid     = r_busy;
    assign o_out.last      = last_w;
    assign o_out.character = r_minus ? CH_MINUS : (CH_ZERO + {2'b00, r_digits[BCD_W-1 -: 4]});

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_minus <= 1'b0;
            r_cnt   <= '0;
        end else if (load) begin
            r_busy  <= 1'b1;
            r_minus <= i_data.neg;
            r_cnt   <= n_nd;
        end else if (xfer) begin
            if (last_w) begin
                r_busy <= 1'b0;
            end
            if (r_minus) begin
                r_minus <= 1'b0;
            end else begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // Digits are left justified on load and shifted out one per transfer.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_digits <= i_data.bcd << n_sh;
        end else if (xfer && !r_minus) begin
            r_digits <= r_digits << 4;
        end
    end

endmodule

// ===== verif/signed_int_to_decimal_ascii_tb.sv =====
module signed_int_to_decimal_ascii_tb;
    import sitda_pkg::*;

    // One expected character of the output text.
    typedef struct packed {
        logic [5:0] character;
        logic       last;
    } t_text_char;

    localparam int NUM_DIRECTED = 20;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int DRAIN_CYCLES = 20;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sitda_in_if  in_if ();
    sitda_out_if out_if ();

    signed_int_to_decimal_ascii i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Characters still owed by the block, oldest first.
    t_text_char pending_chars[$];
    int         error_count = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;

    // Directed values; a non-empty text is the expected output typed in by hand.
    logic [31:0] dir_value [NUM_DIRECTED] = '{
        32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10,
        32'hFFFF_FFF6, 32'd99, 32'd100, 32'h7FFF_FFFF, 32'h8000_0000,
        32'h8000_0001, 32'h7FFF_FFFE, 32'd1000000000, 32'd999999999,
        32'hC465_3601, 32'd1234567890, 32'hB669_FD2E, 32'h5555_5555,
        32'hAAAA_AAAA, 32'd7
    };
    string dir_text [NUM_DIRECTED] = '{
        "0", "1", "-1", "9", "10",
        "-10", "", "", "2147483647", "-2147483648",
        "-2147483647", "", "1000000000", "999999999",
        "", "1234567890", "", "",
        "", ""
    };

    // Clock with a period of 10.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Work out the decimal text of a 32-bit two's complement value.
    function automatic void predict_decimal_text(input logic [31:0] value);
        logic [31:0] magnitude;
        logic [31:0] remainder;
        logic [3:0]  digit_q[$];
        t_text_char  ch;
        int          i;
        magnitude = value[31] ? (32'd0 - value) : value;
        do begin
            remainder = magnitude % 32'd10;
            digit_q.push_front(remainder[3:0]);
            magnitude = magnitude / 32'd10;
        end while (magnitude != 32'd0);
        if (value[31]) begin
            ch.character = CH_MINUS;
            ch.last      = 1'b0;
            pending_chars.push_back(ch);
        end
        for (i = 0; i < digit_q.size(); i++) begin
            ch.character = CH_ZERO + {2'b00, digit_q[i]};
            ch.last      = (i == digit_q.size() - 1);
            pending_chars.push_back(ch);
        end
    endfunction

    // Offer one value and record what it should produce once it is transferred.
    task automatic send_value(input logic [31:0] value, input string text);
        t_text_char ch;
        int         i;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.value <= value;
        do @(posedge i_clk); while (!in_if.ready);
        if (text.len() == 0) begin
            predict_decimal_text(value);
        end else begin
            for (i = 0; i < text.len(); i++) begin
                ch.character = 6'(text.getc(i));
                ch.last      = (i == text.len() - 1);
                pending_chars.push_back(ch);
            end
        end
    endtask

    // Receiver back-pressure, changed at each falling edge.
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Compare every output transfer with the oldest pending character.
    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected character, expected none, actual %0d last %0b",
                         $time, out_if.character, out_if.last);
                error_count++;
            end else begin
                want = pending_chars.pop_front();
                if (out_if.character !== want.character) begin
                    $display("%0t: character mismatch, expected %0d, actual %0d",
                             $time, want.character, out_if.character);
                    error_count++;
                end
                if (out_if.last !== want.last) begin
                    $display("%0t: last mismatch, expected %0b, actual %0b",
                             $time, want.last, out_if.last);
                    error_count++;
                end
            end
        end
    end

    // Stimulus: reset, directed table, then random phases with varying idling and receiver stalls.
    initial begin
        int          phase;
        int          n;
        int          i;
        int          mode;
        int          num_digits;
        longint      lo;
        longint      hi;
        longint      magnitude;
        logic [31:0] value;
        i_rst_n     = 1'b0;
        in_if.valid = 1'b0;
        in_if.value = 32'd0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (n = 0; n < NUM_DIRECTED; n++) begin
            send_value(dir_value[n], dir_text[n]);
        end

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                mode = $urandom_range(0, 9);
                if (mode < 2) begin
                    value = $urandom;
                end else if (mode == 2) begin
                    case ($urandom_range(0, 5))
                        0: value = 32'd0;
                        1: value = 32'hFFFF_FFFF;
                        2: value = 32'h7FFF_FFFF;
                        3: value = 32'h8000_0000;
                        4: value = 32'h8000_0001;
                        default: value = 32'h7FFF_FFFE;
                    endcase
                end else begin
                    // Pick a digit count first so short and long texts are both common.
                    num_digits = $urandom_range(1, 10);
                    lo = 1;
                    for (i = 1; i < num_digits; i++) lo = lo * 10;
                    hi = lo * 10 - 1;
                    if (num_digits == 1) lo = 0;
                    if (hi > 64'sd2147483647) hi = 64'sd2147483647;
                    magnitude = lo + ($urandom % (hi - lo + 1));
                    if ($urandom_range(0, 1)) magnitude = -magnitude;
                    value = magnitude[31:0];
                end
                send_value(value, "");
            end
        end

        @(negedge i_clk);
        in_if.valid <= 1'b0;

        // Drain the outstanding text, then watch for stray characters.
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Give up if the run hangs.
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
design/sitda_pkg.sv
design/sitda_in_if.sv
design/sitda_out_if.sv
design/sitda_dabble.sv
design/sitda_ser.sv
design/signed_int_to_decimal_ascii.sv
verif/signed_int_to_decimal_ascii_tb.sv
